// ----- sv/erft_pkg.sv -----
`default_nettype none
package erft_pkg;

	localparam int COORD_WIDTH_DEF = 36;
	localparam int ANGLE_WIDTH_DEF = 32;

	// CORDIC and fixed-point format of the rotation matrix.
	localparam int CORDIC_STEPS = 30;
	localparam int TRIG_W       = 34;
	localparam int MAT_W        = 35;
	localparam int Q_SHIFT      = 30;
	localparam int NUM_PROD     = 14;
	localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(652032874);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PHI   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THETA = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PSI   = 3'd5;

	typedef enum logic [2:0] {
		RS_LOAD,
		RS_ROT,
		RS_STORE,
		RS_MUL,
		RS_ACC,
		RS_FIN,
		RS_DONE
	} rot_state_t;

	// Row-major rotation matrix in Q30 plus a flag that it is current.
	typedef struct packed {
		logic                        ready;
		logic [8:0][MAT_W-1:0]       m;
	} rot_status_t;

	// Arctangent of 2^-i in 2^-32 turn units.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- sv/erft_pt_if.sv -----
`default_nettype none
interface erft_pt_if #(
	parameter int COORD_WIDTH = erft_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] in_x;
	logic signed [COORD_WIDTH-1:0] in_y;
	logic signed [COORD_WIDTH-1:0] in_z;

	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface
`default_nettype wire

// ----- sv/erft_res_if.sv -----
`default_nettype none
interface erft_res_if #(
	parameter int COORD_WIDTH = erft_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic                          clipped;

	modport source (output valid, out_x, out_y, out_z, clipped, input ready);
	modport sink (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface
`default_nettype wire

// ----- sv/euler_rigid_frame_transform.sv -----
// Channel  Dir  Handshake      Payload
// pts      in   valid/ready    in_x, in_y, in_z (signed, 2^-24 m)
// res      out  valid/ready    out_x, out_y, out_z (signed, saturated), clipped
// cfg      in   cfg_we only    cfg_idx, cfg_wdata
//
// One request per cycle enters unless stalled; each passes six register stages: input,
// nine split products, product merge, pair sums, final sum, round/saturate.
// After reset, and after every angle write, the rotation matrix is rebuilt by a shared
// CORDIC unit and one multiplier, with ready held low meanwhile.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears valid bits, the configuration registers and the matrix sequencer.
`default_nettype none
module euler_rigid_frame_transform #(
	parameter int COORD_WIDTH = erft_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = erft_pkg::ANGLE_WIDTH_DEF,
	localparam int CfgW = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [erft_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CfgW-1:0]                cfg_wdata,
	erft_pt_if.sink                             pts,
	erft_res_if.source                          res
);
	// Translation and angle registers. Only the low bits of a write that fit the
	// register are kept; writes to indexes past the angle registers are dropped.
	logic signed [COORD_WIDTH-1:0] shift_x_q, shift_y_q, shift_z_q;
	logic [ANGLE_WIDTH-1:0]        phi_q, theta_q, psi_q;
	logic                          angle_wr;
	erft_pkg::rot_status_t         rot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
			phi_q     <= '0;
			theta_q   <= '0;
			psi_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				erft_pkg::REG_SHIFT_X:     shift_x_q <= cfg_wdata[COORD_WIDTH-1:0];
				erft_pkg::REG_SHIFT_Y:     shift_y_q <= cfg_wdata[COORD_WIDTH-1:0];
				erft_pkg::REG_SHIFT_Z:     shift_z_q <= cfg_wdata[COORD_WIDTH-1:0];
				erft_pkg::REG_ANGLE_PHI:   phi_q     <= cfg_wdata[ANGLE_WIDTH-1:0];
				erft_pkg::REG_ANGLE_THETA: theta_q   <= cfg_wdata[ANGLE_WIDTH-1:0];
				erft_pkg::REG_ANGLE_PSI:   psi_q     <= cfg_wdata[ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Any angle write makes the current matrix stale, so the sequencer starts over.
	assign angle_wr = cfg_we && (cfg_idx == erft_pkg::REG_ANGLE_PHI ||
		cfg_idx == erft_pkg::REG_ANGLE_THETA || cfg_idx == erft_pkg::REG_ANGLE_PSI);

	// The matrix unit turns the three angles into the Q30 rotation matrix.
	erft_rot_unit #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.angle_phi  (phi_q),
		.angle_theta(theta_q),
		.angle_psi  (psi_q),
		.restart    (angle_wr),
		.rot        (rot)
	);

	// The point pipeline applies the matrix and the translation to each request.
	erft_xform_pipe #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.rot    (rot),
		.shift_x(shift_x_q),
		.shift_y(shift_y_q),
		.shift_z(shift_z_q),
		.pts    (pts),
		.res    (res)
	);
endmodule
`default_nettype wire

// ----- sv/erft_rot_unit.sv -----
`default_nettype none
module erft_rot_unit #(
	parameter int ANGLE_WIDTH = erft_pkg::ANGLE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [ANGLE_WIDTH-1:0] angle_phi,
	input  wire logic [ANGLE_WIDTH-1:0] angle_theta,
	input  wire logic [ANGLE_WIDTH-1:0] angle_psi,
	input  wire logic                   restart,
	output erft_pkg::rot_status_t       rot
);
	localparam int TW = erft_pkg::TRIG_W;
	localparam int PW = 2 * TW;

	erft_pkg::rot_state_t state_q, state_d;

	logic [1:0]              ang_k_q;
	logic [4:0]              iter_q;
	logic [3:0]              step_q;
	logic [1:0]              quad_q;
	logic signed [TW-1:0]    x_q, y_q, z_q;
	logic signed [TW-1:0]    cos_q [3];
	logic signed [TW-1:0]    sin_q [3];
	logic signed [TW-1:0]    prod_q [erft_pkg::NUM_PROD];
	logic signed [PW-1:0]    mul_q;
	logic [8:0][erft_pkg::MAT_W-1:0] m_q;

	logic [ANGLE_WIDTH-1:0]  ang_sel;
	logic [31:0]             ang32, ang_rnd, resid;
	logic [1:0]              quad;
	logic signed [TW-1:0]    atan_v, c_v, s_v, op_a, op_b;
	logic signed [PW-1:0]    rnd;

	always_comb begin
		case (ang_k_q)
			2'd0:    ang_sel = angle_phi;
			2'd1:    ang_sel = angle_theta;
			default: ang_sel = angle_psi;
		endcase
		ang32   = 32'(ang_sel) << (32 - ANGLE_WIDTH);
		ang_rnd = ang32 + 32'h20000000;
		quad    = ang_rnd[31:30];
		resid   = ang32 - {quad, 30'b0};
		atan_v  = TW'(erft_pkg::atan_turn(iter_q));
	end

	// Exact quarter-turn rotation of the CORDIC vector.
	always_comb begin
		case (quad_q)
			2'd0:    begin c_v = x_q;  s_v = y_q;  end
			2'd1:    begin c_v = -y_q; s_v = x_q;  end
			2'd2:    begin c_v = -x_q; s_v = -y_q; end
			default: begin c_v = y_q;  s_v = -x_q; end
		endcase
	end

	// Operand schedule of the shared multiplier. Index 0 is phi, 1 theta, 2 psi.
	always_comb begin
		unique case (step_q)
			4'd0:    begin op_a = cos_q[1];   op_b = cos_q[0]; end
			4'd1:    begin op_a = cos_q[1];   op_b = sin_q[0]; end
			4'd2:    begin op_a = sin_q[2];   op_b = sin_q[1]; end
			4'd3:    begin op_a = prod_q[2];  op_b = cos_q[0]; end
			4'd4:    begin op_a = cos_q[2];   op_b = sin_q[0]; end
			4'd5:    begin op_a = prod_q[2];  op_b = sin_q[0]; end
			4'd6:    begin op_a = cos_q[2];   op_b = cos_q[0]; end
			4'd7:    begin op_a = cos_q[1];   op_b = sin_q[2]; end
			4'd8:    begin op_a = cos_q[2];   op_b = sin_q[1]; end
			4'd9:    begin op_a = prod_q[8];  op_b = cos_q[0]; end
			4'd10:   begin op_a = sin_q[2];   op_b = sin_q[0]; end
			4'd11:   begin op_a = prod_q[8];  op_b = sin_q[0]; end
			4'd12:   begin op_a = sin_q[2];   op_b = cos_q[0]; end
			4'd13:   begin op_a = cos_q[1];   op_b = cos_q[2]; end
			default: begin op_a = '0;         op_b = '0;       end
		endcase
		rnd = (mul_q + (PW'(1) <<< 29)) >>> erft_pkg::Q_SHIFT;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			erft_pkg::RS_LOAD:  state_d = erft_pkg::RS_ROT;
			erft_pkg::RS_ROT:   if (iter_q == 5'(erft_pkg::CORDIC_STEPS - 1)) begin
				state_d = erft_pkg::RS_STORE;
			end
			erft_pkg::RS_STORE: state_d = (ang_k_q == 2'd2) ? erft_pkg::RS_MUL
				: erft_pkg::RS_LOAD;
			erft_pkg::RS_MUL:   state_d = erft_pkg::RS_ACC;
			erft_pkg::RS_ACC:   state_d = (step_q == 4'(erft_pkg::NUM_PROD - 1))
				? erft_pkg::RS_FIN : erft_pkg::RS_MUL;
			erft_pkg::RS_FIN:   state_d = erft_pkg::RS_DONE;
			erft_pkg::RS_DONE:  state_d = erft_pkg::RS_DONE;
			default:            state_d = erft_pkg::RS_LOAD;
		endcase
		if (restart) begin
			state_d = erft_pkg::RS_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erft_pkg::RS_LOAD;
			ang_k_q <= '0;
			step_q  <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				ang_k_q <= '0;
				step_q  <= '0;
			end else begin
				case (state_q)
					erft_pkg::RS_LOAD:  iter_q <= '0;
					erft_pkg::RS_ROT:   iter_q <= iter_q + 5'd1;
					erft_pkg::RS_STORE: ang_k_q <= ang_k_q + 2'd1;
					erft_pkg::RS_ACC:   step_q <= step_q + 4'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			erft_pkg::RS_LOAD: begin
				x_q    <= erft_pkg::CORDIC_START;
				y_q    <= '0;
				z_q    <= TW'($signed(resid));
				quad_q <= quad;
			end
			erft_pkg::RS_ROT: begin
				if (!z_q[TW-1]) begin
					x_q <= x_q - (y_q >>> iter_q);
					y_q <= y_q + (x_q >>> iter_q);
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + (y_q >>> iter_q);
					y_q <= y_q - (x_q >>> iter_q);
					z_q <= z_q + atan_v;
				end
			end
			erft_pkg::RS_STORE: begin
				cos_q[ang_k_q] <= c_v;
				sin_q[ang_k_q] <= s_v;
			end
			erft_pkg::RS_MUL: mul_q <= op_a * op_b;
			erft_pkg::RS_ACC: prod_q[step_q] <= TW'(rnd);
			erft_pkg::RS_FIN: begin
				m_q[0] <= erft_pkg::MAT_W'(prod_q[0]);
				m_q[1] <= erft_pkg::MAT_W'(prod_q[1]);
				m_q[2] <= -erft_pkg::MAT_W'(sin_q[1]);
				m_q[3] <= erft_pkg::MAT_W'(prod_q[3]) - erft_pkg::MAT_W'(prod_q[4]);
				m_q[4] <= erft_pkg::MAT_W'(prod_q[5]) + erft_pkg::MAT_W'(prod_q[6]);
				m_q[5] <= erft_pkg::MAT_W'(prod_q[7]);
				m_q[6] <= erft_pkg::MAT_W'(prod_q[9]) + erft_pkg::MAT_W'(prod_q[10]);
				m_q[7] <= erft_pkg::MAT_W'(prod_q[11]) - erft_pkg::MAT_W'(prod_q[12]);
				m_q[8] <= erft_pkg::MAT_W'(prod_q[13]);
			end
			default: ;
		endcase
	end

	assign rot.ready = (state_q == erft_pkg::RS_DONE) && !restart;
	assign rot.m     = m_q;

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == erft_pkg::RS_ROT |-> iter_q < 5'(erft_pkg::CORDIC_STEPS))
		else $error("CORDIC step counter ran past its last step");
	a_restart_drops: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !rot.ready)
		else $error("matrix flagged ready right after an angle write");
	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == erft_pkg::RS_ACC && !restart |=>
		state_q == erft_pkg::RS_MUL || state_q == erft_pkg::RS_FIN)
		else $error("product sequence left its loop");
endmodule
`default_nettype wire

// ----- sv/erft_xform_pipe.sv -----
`default_nettype none
module erft_xform_pipe #(
	parameter int COORD_WIDTH = erft_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire erft_pkg::rot_status_t         rot,
	input  wire logic signed [COORD_WIDTH-1:0] shift_x,
	input  wire logic signed [COORD_WIDTH-1:0] shift_y,
	input  wire logic signed [COORD_WIDTH-1:0] shift_z,
	erft_pt_if.sink                            pts,
	erft_res_if.source                         res
);
	localparam int MW    = erft_pkg::MAT_W;
	localparam int LO_W  = COORD_WIDTH / 2;
	localparam int HI_W  = COORD_WIDTH - LO_W;
	localparam int PH_W  = MW + HI_W;
	localparam int PL_W  = MW + LO_W + 1;
	localparam int ACC_W = COORD_WIDTH + MW + 3;
	localparam int SH_W  = ACC_W - erft_pkg::Q_SHIFT;
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, valid_q;

	logic signed [COORD_WIDTH-1:0] p_s1 [3];
	logic signed [PH_W-1:0]        ph_s2 [3][3];
	logic signed [PL_W-1:0]        pl_s2 [3][3];
	logic signed [ACC_W-1:0]       term_s3 [3][3];
	logic signed [ACC_W-1:0]       a_s4 [3];
	logic signed [ACC_W-1:0]       b_s4 [3];
	logic signed [ACC_W-1:0]       sum_s5 [3];
	logic signed [COORD_WIDTH-1:0] out_q [3];
	logic                          clip_q;

	logic signed [COORD_WIDTH-1:0] shift [3];
	logic signed [SH_W-1:0]        sh [3];
	logic signed [COORD_WIDTH-1:0] sat [3];
	logic [2:0]                    ovf;

	assign adv       = !valid_q || res.ready;
	assign pts.ready = adv && rot.ready;
	assign shift[0]  = shift_x;
	assign shift[1]  = shift_y;
	assign shift[2]  = shift_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]  = SH_W'(sum_s5[i] >>> erft_pkg::Q_SHIFT);
			ovf[i] = sh[i] != SH_W'($signed(sh[i][COORD_WIDTH-1:0]));
			sat[i] = ovf[i] ? (sh[i][SH_W-1] ? C_MIN : C_MAX) : sh[i][COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pts.valid && pts.ready;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= pts.in_x;
			p_s1[1] <= pts.in_y;
			p_s1[2] <= pts.in_z;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s2[i][j] <= PH_W'($signed(rot.m[3*i+j]))
						* PH_W'($signed(p_s1[j][COORD_WIDTH-1:LO_W]));
					pl_s2[i][j] <= PL_W'($signed(rot.m[3*i+j]))
						* PL_W'($signed({1'b0, p_s1[j][LO_W-1:0]}));
					term_s3[i][j] <= (ACC_W'(ph_s2[i][j]) <<< LO_W) + ACC_W'(pl_s2[i][j]);
				end
				a_s4[i]   <= term_s3[i][0] + term_s3[i][1];
				b_s4[i]   <= term_s3[i][2] + (ACC_W'(shift[i]) <<< erft_pkg::Q_SHIFT)
					+ (ACC_W'(1) <<< (erft_pkg::Q_SHIFT - 1));
				sum_s5[i] <= a_s4[i] + b_s4[i];
				out_q[i]  <= sat[i];
			end
			clip_q <= |ovf;
		end
	end

	assign res.valid   = valid_q;
	assign res.out_x   = out_q[0];
	assign res.out_y   = out_q[1];
	assign res.out_z   = out_q[2];
	assign res.clipped = clip_q;

	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.clipped |->
		res.out_x == C_MAX || res.out_x == C_MIN || res.out_y == C_MAX ||
		res.out_y == C_MIN || res.out_z == C_MAX || res.out_z == C_MIN)
		else $error("clipped set with no component at a bound");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s3 |=> v_s3)
		else $error("stage three lost an item during a stall");
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !pts.ready)
		else $error("request taken while the pipeline is frozen");
endmodule
`default_nettype wire
